// File: sv/mba_pkg.sv
// Shared types and constants for the mosaic block average unit.
// No dependencies; imported by the top level, the checker and the testbench.
package mba_pkg;

    localparam int CW = 14;

    typedef logic [1:0] op_t;
    localparam op_t OP_WRITE = 2'd0;
    localparam op_t OP_RUN   = 2'd1;
    localparam op_t OP_READ  = 2'd2;

    typedef logic [3:0] reg_idx_t;
    localparam reg_idx_t REG_IMAGE_WIDTH  = 4'd0;
    localparam reg_idx_t REG_IMAGE_HEIGHT = 4'd1;
    localparam reg_idx_t REG_RECT_LEFT    = 4'd2;
    localparam reg_idx_t REG_RECT_TOP     = 4'd3;
    localparam reg_idx_t REG_RECT_RIGHT   = 4'd4;
    localparam reg_idx_t REG_RECT_BOTTOM  = 4'd5;
    localparam reg_idx_t REG_BLOCK_SIZE   = 4'd6;
    localparam reg_idx_t REG_BRIGHTNESS   = 4'd7;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic [7:0] chan_t;

    localparam chan_t CHAN_MAX = 8'd255;
    localparam int    BRIGHT_BIAS = 256;

    function automatic coord_t ext10(input logic [9:0] v);
        ext10 = signed'({{(CW-10){1'b0}}, v});
    endfunction

endpackage

// File: sv/mba_if.sv
// Channel interfaces: pixel command, response and configuration write.
// Depends on nothing but plain logic types.
interface mba_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [8:0] x_pos;
    logic [8:0] y_pos;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    modport source (output valid, operation, x_pos, y_pos, red_in, green_in, blue_in,
                    input ready);
    modport sink   (input valid, operation, x_pos, y_pos, red_in, green_in, blue_in,
                    output ready);
endinterface

interface mba_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       run_done;
    modport source (output valid, red_out, green_out, blue_out, run_done, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, run_done, output ready);
endinterface

interface mba_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [11:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/mosaic_block_average_unit.sv
// Mosaic block average unit: frame store plus in-place pixelate sequencer.
// Depends on mba_pkg and the channel interfaces in mba_if.sv.
//
// Usage:
//   cmd carries one word per operation: write pixel, read pixel or run mosaic.
//   rsp returns one word per read (colour, run_done 0) and per run (run_done 1).
//   The user must do cfg register writes only while idle; cfg is always ready.
// Sequencing:
//   A write enters the frame store in the cycle it is accepted. A read goes
//   through the frame store read register into the output register; the next
//   word is taken once the read data sits in the output register. A run clips
//   the rectangle in one step and makes two 10-step remainder passes, then per
//   block one frame store read port sums the block, a 9-step divider forms the
//   mean, and the write port fills it. The frame store is a single-port-read,
//   single-port-write RAM with a registered read; it sets the per-pixel rate.
// Reset:
//   Config and control registers go to defaults; frame store is not cleared.
// Stalls:
//   A pending response holds in the output register; no new word is taken
//   until it is gone or leaves in the same cycle.
module mosaic_block_average_unit #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input logic       clk,
    input logic       rst_n,
    mba_cmd_if.sink   cmd,
    mba_rsp_if.source rsp,
    mba_cfg_if.sink   cfg
);
    import mba_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam coord_t MAXW_S = CW'(MAX_WIDTH);
    localparam coord_t MAXH_S = CW'(MAX_HEIGHT);

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_MODX, S_MODY, S_BLK, S_SUM, S_SUMW,
        S_SCALE, S_DIV, S_FILL, S_NEXT, S_FIN
    } state_t;

    // configuration
    logic [9:0]         img_w_reg, img_h_reg, size_cfg_reg;
    logic signed [11:0] rl_reg, rt_reg, rr_reg, rb_reg;
    logic signed [9:0]  bright_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg    <= 10'd512;
            img_h_reg    <= 10'd512;
            rl_reg       <= 12'sd0;
            rt_reg       <= 12'sd0;
            rr_reg       <= 12'sd512;
            rb_reg       <= 12'sd512;
            size_cfg_reg <= 10'd8;
            bright_reg   <= 10'sd0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_IMAGE_WIDTH:  img_w_reg    <= cfg.data[9:0];
                REG_IMAGE_HEIGHT: img_h_reg    <= cfg.data[9:0];
                REG_RECT_LEFT:    rl_reg       <= signed'(cfg.data);
                REG_RECT_TOP:     rt_reg       <= signed'(cfg.data);
                REG_RECT_RIGHT:   rr_reg       <= signed'(cfg.data);
                REG_RECT_BOTTOM:  rb_reg       <= signed'(cfg.data);
                REG_BLOCK_SIZE:   size_cfg_reg <= cfg.data[9:0];
                REG_BRIGHTNESS:   bright_reg   <= signed'(cfg.data[9:0]);
                default:          ;
            endcase
        end
    end

    // effective image size
    coord_t w_s, h_s;
    always_comb
    begin
        w_s = ext10(img_w_reg);
        h_s = ext10(img_h_reg);
        if (w_s > MAXW_S)
            w_s = MAXW_S;
        if (h_s > MAXH_S)
            h_s = MAXH_S;
    end

    function automatic logic [AW-1:0] addr_of(input logic [12:0] xx, input logic [12:0] yy);
        addr_of = AW'(yy) * AW'(MAX_WIDTH) + AW'(xx);
    endfunction

    // frame store
    logic [23:0]   mem [DEPTH];
    logic [23:0]   mem_q;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [23:0]   mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_q <= mem[mem_raddr];
    end

    // sequencer registers
    state_t      state_reg, state_next;
    coord_t      lc_reg, tc_reg, rc_reg, bc_reg;
    coord_t      lc_next, tc_next, rc_next, bc_next;
    logic [9:0]  size_reg, size_next, fact_reg, fact_next;
    logic        bnz_reg, bnz_next;
    logic [9:0]  sx_reg, sx_next, sy_reg, sy_next;
    logic [9:0]  modd_reg, modd_next, rem_reg, rem_next;
    logic [3:0]  bit_reg, bit_next, k_reg, k_next;
    coord_t      i_reg, i_next, j_reg, j_next;
    coord_t      bx_reg, bx_next, by_reg, by_next;
    coord_t      xe_reg, xe_next, ye_reg, ye_next;
    coord_t      cx_reg, cx_next, cy_reg, cy_next;
    logic [9:0]  bw_reg, bw_next, bh_reg, bh_next;
    logic [25:0] sum_reg [3];
    logic [25:0] sum_next [3];
    logic [27:0] num_reg [3];
    logic [27:0] num_next [3];
    logic [8:0]  quo_reg [3];
    logic [8:0]  quo_next [3];
    logic [19:0] npix_reg, npix_next;
    logic        sum_vld_reg, sum_vld_next;
    logic        rd_pend_reg, rd_pend_next, rd_in_reg, rd_in_next;
    logic        out_valid_reg, out_valid_next, out_done_reg, out_done_next;
    logic [23:0] out_rgb_reg, out_rgb_next;

    logic        in_ready, accept, in_image;
    coord_t      xin_s, yin_s;
    logic [23:0] colour;

    assign xin_s    = ext10({1'b0, cmd.x_pos});
    assign yin_s    = ext10({1'b0, cmd.y_pos});
    assign in_image = (xin_s < w_s) && (yin_s < h_s);
    assign in_ready = (state_reg == S_IDLE) && !rd_pend_reg
                      && (!out_valid_reg || rsp.ready);
    assign accept   = cmd.valid && in_ready;
    assign cmd.ready = in_ready;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
            colour[23-8*c -: 8] = quo_reg[c][8] ? CHAN_MAX : quo_reg[c][7:0];
    end

    // memory port muxes
    always_comb
    begin
        mem_raddr = addr_of({4'b0, cmd.x_pos}, {4'b0, cmd.y_pos});
        mem_waddr = addr_of({4'b0, cmd.x_pos}, {4'b0, cmd.y_pos});
        mem_wdata = {cmd.red_in, cmd.green_in, cmd.blue_in};
        mem_we    = accept && (cmd.operation == OP_WRITE) && in_image;
        if (state_reg == S_SUM)
            mem_raddr = addr_of(cx_reg[12:0], cy_reg[12:0]);
        if (state_reg == S_FILL)
        begin
            mem_waddr = addr_of(cx_reg[12:0], cy_reg[12:0]);
            mem_wdata = colour;
            mem_we    = 1'b1;
        end
    end

    // setup and step helpers
    coord_t l_s, t_s, r_s, b_s, lcl, tcl, rcl, bcl, sz, bws, bhs, inx, jn;
    coord_t bright_s;
    logic        skip, last_px;
    logic [10:0] mod_t;
    logic [9:0]  mod_r, mod_fix;
    logic [27:0] dshift;
    logic [35:0] prod;

    always_comb
    begin
        l_s = CW'(rl_reg);
        t_s = CW'(rt_reg);
        r_s = CW'(rr_reg);
        b_s = CW'(rb_reg);
        skip = (size_cfg_reg <= 10'd1) || (r_s < 0) || (b_s < 0)
               || (l_s > w_s - 1) || (t_s > h_s - 1);
        lcl = (l_s < 0) ? '0 : l_s;
        tcl = (t_s < 0) ? '0 : t_s;
        rcl = (r_s > w_s) ? w_s : r_s;
        bcl = (b_s > h_s) ? h_s : b_s;
        bright_s = CW'(bright_reg);
        if (bright_s < -CW'(BRIGHT_BIAS))
            bright_s = -CW'(BRIGHT_BIAS);
        if (bright_s > CW'(BRIGHT_BIAS))
            bright_s = CW'(BRIGHT_BIAS);

        mod_t   = {rem_reg, modd_reg[bit_reg]};
        mod_r   = (mod_t >= {1'b0, size_reg}) ? 10'(mod_t - {1'b0, size_reg}) : mod_t[9:0];
        mod_fix = (mod_r == 10'd0) ? 10'd0 : 10'(size_reg - mod_r);

        sz = ext10(size_reg);
        last_px = (cx_reg == xe_reg) && (cy_reg == ye_reg);
        inx = i_reg + sz;
        jn  = j_reg + sz;
        dshift = 28'(npix_reg) << k_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        lc_next = lc_reg; tc_next = tc_reg; rc_next = rc_reg; bc_next = bc_reg;
        size_next = size_reg; fact_next = fact_reg; bnz_next = bnz_reg;
        sx_next = sx_reg; sy_next = sy_reg;
        modd_next = modd_reg; rem_next = rem_reg; bit_next = bit_reg; k_next = k_reg;
        i_next = i_reg; j_next = j_reg;
        bx_next = bx_reg; by_next = by_reg; xe_next = xe_reg; ye_next = ye_reg;
        cx_next = cx_reg; cy_next = cy_reg; bw_next = bw_reg; bh_next = bh_reg;
        npix_next = npix_reg;
        bws  = '0;
        bhs  = '0;
        prod = '0;
        for (int c = 0; c < 3; c++)
        begin
            sum_next[c] = sum_reg[c];
            num_next[c] = num_reg[c];
            quo_next[c] = quo_reg[c];
        end
        sum_vld_next   = (state_reg == S_SUM);
        rd_pend_next   = 1'b0;
        rd_in_next     = rd_in_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_done_next  = out_done_reg;
        out_rgb_next   = out_rgb_reg;

        if (sum_vld_reg)
            for (int c = 0; c < 3; c++)
                sum_next[c] = sum_reg[c] + 26'(mem_q[23-8*c -: 8]);

        if (rd_pend_reg)
        begin
            out_valid_next = 1'b1;
            out_done_next  = 1'b0;
            out_rgb_next   = rd_in_reg ? mem_q : 24'd0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && cmd.operation == OP_READ)
                begin
                    rd_pend_next = 1'b1;
                    rd_in_next   = in_image;
                end
                if (accept && cmd.operation == OP_RUN)
                    state_next = S_SETUP;
            end
            S_SETUP:
            begin
                lc_next   = lcl;
                tc_next   = tcl;
                rc_next   = rcl;
                bc_next   = bcl;
                size_next = size_cfg_reg;
                bnz_next  = (bright_s != 0);
                fact_next = 10'(bright_s + CW'(BRIGHT_BIAS));
                modd_next = 10'((rcl - lcl) >>> 1);
                rem_next  = '0;
                bit_next  = 4'd9;
                if (skip || (rcl <= lcl) || (bcl <= tcl))
                    state_next = S_FIN;
                else
                    state_next = S_MODX;
            end
            S_MODX:
            begin
                rem_next = mod_r;
                bit_next = bit_reg - 4'd1;
                if (bit_reg == 4'd0)
                begin
                    sx_next    = mod_fix;
                    modd_next  = 10'((bc_reg - tc_reg) >>> 1);
                    rem_next   = '0;
                    bit_next   = 4'd9;
                    state_next = S_MODY;
                end
            end
            S_MODY:
            begin
                rem_next = mod_r;
                bit_next = bit_reg - 4'd1;
                if (bit_reg == 4'd0)
                begin
                    sy_next    = mod_fix;
                    i_next     = lc_reg - ext10(sx_reg);
                    j_next     = tc_reg - ext10(mod_fix);
                    state_next = S_BLK;
                end
            end
            S_BLK:
            begin
                if (j_reg < tc_reg)
                begin
                    by_next = tc_reg;
                    bhs = sz - ext10(sy_reg);
                    if (bhs > bc_reg - tc_reg)
                        bhs = bc_reg - tc_reg;
                end
                else
                begin
                    by_next = j_reg;
                    bhs = (bc_reg - j_reg < sz) ? bc_reg - j_reg : sz;
                end
                if (i_reg < lc_reg)
                begin
                    bx_next = lc_reg;
                    bws = sz - ext10(sx_reg);
                    if (bws > rc_reg - lc_reg)
                        bws = rc_reg - lc_reg;
                end
                else
                begin
                    bx_next = i_reg;
                    bws = (rc_reg - i_reg < sz) ? rc_reg - i_reg : sz;
                end
                bw_next = bws[9:0];
                bh_next = bhs[9:0];
                xe_next = bx_next + bws - CW'(1);
                ye_next = by_next + bhs - CW'(1);
                cx_next = bx_next;
                cy_next = by_next;
                for (int c = 0; c < 3; c++)
                    sum_next[c] = '0;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                if (cx_reg == xe_reg)
                begin
                    cx_next = bx_reg;
                    cy_next = cy_reg + CW'(1);
                end
                else
                    cx_next = cx_reg + CW'(1);
                if (last_px)
                    state_next = S_SUMW;
            end
            S_SUMW:
                state_next = S_SCALE;
            S_SCALE:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod = 36'(sum_reg[c]) * 36'(fact_reg);
                    num_next[c] = bnz_reg ? prod[35:8] : 28'(sum_reg[c]);
                    quo_next[c] = '0;
                end
                npix_next  = 20'(bw_reg) * 20'(bh_reg);
                k_next     = 4'd8;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                for (int c = 0; c < 3; c++)
                    if (num_reg[c] >= dshift)
                    begin
                        num_next[c] = num_reg[c] - dshift;
                        quo_next[c][k_reg] = 1'b1;
                    end
                k_next = k_reg - 4'd1;
                if (k_reg == 4'd0)
                begin
                    cx_next    = bx_reg;
                    cy_next    = by_reg;
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                if (cx_reg == xe_reg)
                begin
                    cx_next = bx_reg;
                    cy_next = cy_reg + CW'(1);
                end
                else
                    cx_next = cx_reg + CW'(1);
                if (last_px)
                    state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (inx >= rc_reg)
                begin
                    i_next = lc_reg - ext10(sx_reg);
                    j_next = jn;
                    state_next = (jn >= bc_reg) ? S_FIN : S_BLK;
                end
                else
                begin
                    i_next     = inx;
                    state_next = S_BLK;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_done_next  = 1'b1;
                    out_rgb_next   = 24'd0;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sum_vld_reg   <= 1'b0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_vld_reg   <= sum_vld_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lc_reg <= lc_next; tc_reg <= tc_next; rc_reg <= rc_next; bc_reg <= bc_next;
        size_reg <= size_next; fact_reg <= fact_next; bnz_reg <= bnz_next;
        sx_reg <= sx_next; sy_reg <= sy_next;
        modd_reg <= modd_next; rem_reg <= rem_next; bit_reg <= bit_next; k_reg <= k_next;
        i_reg <= i_next; j_reg <= j_next;
        bx_reg <= bx_next; by_reg <= by_next; xe_reg <= xe_next; ye_reg <= ye_next;
        cx_reg <= cx_next; cy_reg <= cy_next; bw_reg <= bw_next; bh_reg <= bh_next;
        npix_reg <= npix_next;
        for (int c = 0; c < 3; c++)
        begin
            sum_reg[c] <= sum_next[c];
            num_reg[c] <= num_next[c];
            quo_reg[c] <= quo_next[c];
        end
        rd_in_reg    <= rd_in_next;
        out_done_reg <= out_done_next;
        out_rgb_reg  <= out_rgb_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.red_out   = out_rgb_reg[23:16];
    assign rsp.green_out = out_rgb_reg[15:8];
    assign rsp.blue_out  = out_rgb_reg[7:0];
    assign rsp.run_done  = out_done_reg;

endmodule

// File: sv/mba_checker.sv
// Port-level checks for the mosaic block average unit, bound to the top level.
// Depends on mba_pkg and mosaic_block_average_unit.
module mba_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic [1:0] cmd_operation,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [7:0] rsp_red,
    input logic [7:0] rsp_green,
    input logic [7:0] rsp_blue,
    input logic       rsp_done
);
    import mba_pkg::*;

    logic cmd_acc;
    assign cmd_acc = cmd_valid && cmd_ready;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid
            && $stable({rsp_red, rsp_green, rsp_blue, rsp_done}))
        else $error("stalled response word changed");

    a_no_take_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready && rsp_valid |-> rsp_ready)
        else $error("command taken while response stalled");

    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_acc && cmd_operation == OP_WRITE && !rsp_valid |=> !rsp_valid)
        else $error("write produced a response");

    a_read_answers: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_acc && cmd_operation == OP_READ |-> ##2 rsp_valid && !rsp_done)
        else $error("read response missing");

endmodule

bind mosaic_block_average_unit mba_checker u_mba_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .cmd_operation (cmd.operation),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_red       (rsp.red_out),
    .rsp_green     (rsp.green_out),
    .rsp_blue      (rsp.blue_out),
    .rsp_done      (rsp.run_done)
);

// File: dv/tb_mosaic_block_average_unit.sv
// Self-checking testbench for mosaic_block_average_unit: pixel loads, reads and
// in-place mosaic runs checked word by word against an in-bench frame model.
// Depends on mba_pkg and the channel interfaces in sv/mba_if.sv.
module tb_mosaic_block_average_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import mba_pkg::*;

    localparam int FRAME_W   = 512;
    localparam int FRAME_H   = 512;
    localparam int FRAME_PIX = FRAME_W * FRAME_H;

    typedef struct packed {
        op_t        op;
        logic [8:0] x;
        logic [8:0] y;
        chan_t      r;
        chan_t      g;
        chan_t      b;
    } pix_cmd_t;

    typedef struct packed {
        chan_t r;
        chan_t g;
        chan_t b;
        logic  done;
    } pix_rsp_t;

    localparam op_t OP_NONE = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    mba_cmd_if cmd ();
    mba_rsp_if rsp ();
    mba_cfg_if cfg ();

    mosaic_block_average_unit #(
        .MAX_WIDTH  (FRAME_W),
        .MAX_HEIGHT (FRAME_H)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    pix_cmd_t    cmd_pending[$];
    pix_rsp_t    rsp_expected[$];
    logic [23:0] frame_model[FRAME_PIX];
    bit          gen_written[FRAME_PIX];
    logic [11:0] cfg_shadow[16];
    int          error_count;
    int          reads_checked;
    int          runs_checked;
    int          pixels_written;
    bit          rx_hold;
    bit          hold_go;

    // ---------------- frame model ----------------
    function automatic int eff_dim(input logic [11:0] v, input int maxv);
        int d;
        d = int'(v[9:0]);
        return (d > maxv) ? maxv : d;
    endfunction

    function automatic int s12(input logic [11:0] v);
        return int'($signed(v));
    endfunction

    function automatic void average_block(input int bx, input int by, input int bw,
                                          input int bh, input int bright);
        longint      sum[3];
        longint      v;
        logic [23:0] colour;
        logic [23:0] p;
        int          x;
        int          y;
        int          c;
        sum = '{0, 0, 0};
        for (y = by; y < by + bh; y++)
            for (x = bx; x < bx + bw; x++)
            begin
                p = frame_model[y * FRAME_W + x];
                sum[0] += p[23:16];
                sum[1] += p[15:8];
                sum[2] += p[7:0];
            end
        colour = '0;
        for (c = 0; c < 3; c++)
        begin
            v = sum[c];
            if (bright != 0)
                v = (v * (bright + BRIGHT_BIAS)) >>> 8;
            v = v / (longint'(bw) * bh);
            if (v > CHAN_MAX)
                v = CHAN_MAX;
            colour = {colour[15:0], v[7:0]};
        end
        for (y = by; y < by + bh; y++)
            for (x = bx; x < bx + bw; x++)
                frame_model[y * FRAME_W + x] = colour;
    endfunction

    function automatic void mosaic_run();
        int w, h, l, t, r, b, sz, br, sx, sy, i, j, bx, by, bw, bh;
        w  = eff_dim(cfg_shadow[REG_IMAGE_WIDTH], FRAME_W);
        h  = eff_dim(cfg_shadow[REG_IMAGE_HEIGHT], FRAME_H);
        l  = s12(cfg_shadow[REG_RECT_LEFT]);
        t  = s12(cfg_shadow[REG_RECT_TOP]);
        r  = s12(cfg_shadow[REG_RECT_RIGHT]);
        b  = s12(cfg_shadow[REG_RECT_BOTTOM]);
        sz = int'(cfg_shadow[REG_BLOCK_SIZE][9:0]);
        br = int'($signed(cfg_shadow[REG_BRIGHTNESS][9:0]));
        if (sz <= 1)
            return;
        if (br < -BRIGHT_BIAS) br = -BRIGHT_BIAS;
        if (br > BRIGHT_BIAS) br = BRIGHT_BIAS;
        if (r < 0 || b < 0 || l > w - 1 || t > h - 1)
            return;
        if (l < 0) l = 0;
        if (t < 0) t = 0;
        if (r > w) r = w;
        if (b > h) b = h;
        if (r <= l || b <= t)
            return;
        sx = ((r - l) >> 1) % sz;
        if (sx != 0) sx = sz - sx;
        sy = ((b - t) >> 1) % sz;
        if (sy != 0) sy = sz - sy;
        for (j = t - sy; j < b; j += sz)
        begin
            if (j < t)
            begin
                by = t;
                bh = sz - sy;
                if (bh > b - t) bh = b - t;
            end
            else
            begin
                by = j;
                bh = (b - j < sz) ? b - j : sz;
            end
            for (i = l - sx; i < r; i += sz)
            begin
                if (i < l)
                begin
                    bx = l;
                    bw = sz - sx;
                    if (bw > r - l) bw = r - l;
                end
                else
                begin
                    bx = i;
                    bw = (r - i < sz) ? r - i : sz;
                end
                average_block(bx, by, bw, bh, br);
            end
        end
    endfunction

    // ---------------- command driver ----------------
    int tx_gap;

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 60) return 0;
        if (k < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd.valid <= 1'b0;
            tx_gap    <= 0;
        end
        else if (!cmd.valid || cmd.ready)
        begin
            if (tx_gap > 0)
            begin
                cmd.valid <= 1'b0;
                tx_gap    <= tx_gap - 1;
            end
            else if (cmd_pending.size() > 0)
            begin
                pix_cmd_t c;
                c = cmd_pending.pop_front();
                cmd.valid     <= 1'b1;
                cmd.operation <= c.op;
                cmd.x_pos     <= c.x;
                cmd.y_pos     <= c.y;
                cmd.red_in    <= c.r;
                cmd.green_in  <= c.g;
                cmd.blue_in   <= c.b;
                tx_gap        <= pick_gap();
            end
            else
                cmd.valid <= 1'b0;
        end
    end

    // ---------------- response ready ----------------
    int rx_gap;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            rx_gap    <= 0;
        end
        else if (rx_hold)
            rsp.ready <= 1'b0;
        else if (rx_gap > 0)
        begin
            rsp.ready <= 1'b0;
            rx_gap    <= rx_gap - 1;
        end
        else
        begin
            rsp.ready <= 1'b1;
            if (rsp.valid && rsp.ready)
                rx_gap <= pick_gap();
        end
    end

    initial
    begin
        rx_hold = 1'b0;
        wait (hold_go);
        repeat (150) @(posedge clk);
        rx_hold = 1'b1;
        repeat (400) @(posedge clk);
        rx_hold = 1'b0;
    end

    // ---------------- monitors and predictor ----------------
    always @(posedge clk)
    begin
        if (rst_n && cfg.valid && cfg.ready)
            cfg_shadow[cfg.index] <= cfg.data;
    end

    always @(posedge clk)
    begin
        if (rst_n && cmd.valid && cmd.ready)
        begin
            int w, h;
            bit in_img;
            int a;
            w      = eff_dim(cfg_shadow[REG_IMAGE_WIDTH], FRAME_W);
            h      = eff_dim(cfg_shadow[REG_IMAGE_HEIGHT], FRAME_H);
            in_img = (int'(cmd.x_pos) < w) && (int'(cmd.y_pos) < h);
            a      = int'(cmd.y_pos) * FRAME_W + int'(cmd.x_pos);
            case (cmd.operation)
                OP_WRITE:
                    if (in_img)
                    begin
                        frame_model[a] = {cmd.red_in, cmd.green_in, cmd.blue_in};
                        pixels_written++;
                    end
                OP_RUN:
                begin
                    mosaic_run();
                    rsp_expected.push_back('{8'd0, 8'd0, 8'd0, 1'b1});
                end
                OP_READ:
                begin
                    logic [23:0] p;
                    p = in_img ? frame_model[a] : 24'd0;
                    rsp_expected.push_back('{p[23:16], p[15:8], p[7:0], 1'b0});
                end
                default: ;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (rsp_expected.size() == 0)
            begin
                $error("unexpected response word: r=%0d g=%0d b=%0d done=%0d",
                       rsp.red_out, rsp.green_out, rsp.blue_out, rsp.run_done);
                error_count++;
            end
            else
            begin
                pix_rsp_t e;
                e = rsp_expected.pop_front();
                if (rsp.red_out !== e.r)
                begin
                    $error("red_out exp %0d got %0d", e.r, rsp.red_out);
                    error_count++;
                end
                if (rsp.green_out !== e.g)
                begin
                    $error("green_out exp %0d got %0d", e.g, rsp.green_out);
                    error_count++;
                end
                if (rsp.blue_out !== e.b)
                begin
                    $error("blue_out exp %0d got %0d", e.b, rsp.blue_out);
                    error_count++;
                end
                if (rsp.run_done !== e.done)
                begin
                    $error("run_done exp %0d got %0d", e.done, rsp.run_done);
                    error_count++;
                end
                if (e.done) runs_checked++;
                else reads_checked++;
            end
        end
    end

    // ---------------- stimulus ----------------
    int cur_w;
    int cur_h;

    function automatic void push_cmd(input op_t op, input int x, input int y,
                                     input int r, input int g, input int b);
        cmd_pending.push_back('{op, x[8:0], y[8:0], r[7:0], g[7:0], b[7:0]});
        if (op == OP_WRITE && x < cur_w && y < cur_h)
            gen_written[y * FRAME_W + x] = 1'b1;
    endfunction

    function automatic void push_write(input int x, input int y);
        push_cmd(OP_WRITE, x, y, $urandom, $urandom, $urandom);
    endfunction

    // every pixel of the current image gets a value before any run can read it
    function automatic void fill_image();
        int x, y;
        for (y = 0; y < cur_h; y++)
            for (x = 0; x < cur_w; x++)
                if (!gen_written[y * FRAME_W + x])
                    push_write(x, y);
    endfunction

    task automatic drain();
        do @(posedge clk);
        while (cmd_pending.size() != 0 || cmd.valid || rsp_expected.size() != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic apply_cfg(input logic [11:0] w, input logic [11:0] h,
                             input logic [11:0] l, input logic [11:0] t,
                             input logic [11:0] r, input logic [11:0] b,
                             input logic [11:0] sz, input logic [11:0] br);
        reg_idx_t    idx[8];
        logic [11:0] val[8];
        drain();
        idx = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_RECT_LEFT, REG_RECT_TOP,
                REG_RECT_RIGHT, REG_RECT_BOTTOM, REG_BLOCK_SIZE, REG_BRIGHTNESS};
        val = '{w, h, l, t, r, b, sz, br};
        foreach (idx[k])
        begin
            cfg.valid <= 1'b1;
            cfg.index <= idx[k];
            cfg.data  <= val[k];
            do @(posedge clk);
            while (!cfg.ready);
        end
        cfg.valid <= 1'b0;
        cur_w = eff_dim(w, FRAME_W);
        cur_h = eff_dim(h, FRAME_H);
        fill_image();
    endtask

    function automatic void random_items(input int n);
        int k, sel, x, y;
        for (k = 0; k < n; k++)
        begin
            sel = $urandom_range(0, 99);
            x   = (cur_w > 0) ? $urandom_range(0, cur_w - 1) : 0;
            y   = (cur_h > 0) ? $urandom_range(0, cur_h - 1) : 0;
            if (sel < 8)
                push_cmd(OP_RUN, $urandom_range(0, 511), $urandom_range(0, 511),
                         $urandom, $urandom, $urandom);
            else if (sel < 12)
                push_cmd(OP_NONE, $urandom_range(0, 511), $urandom_range(0, 511),
                         $urandom, $urandom, $urandom);
            else if (sel < 20)
            begin
                x = $urandom_range(0, 511);
                y = $urandom_range(0, 511);
                if (x < cur_w && y < cur_h) x = cur_w;
                if (x > 511) y = cur_h;
                if (x > 511) x = 0;
                if (y > 511)
                    push_cmd(OP_READ, x, y, 0, 0, 0);
                else
                    push_cmd(($urandom_range(0, 1) != 0) ? OP_READ : OP_WRITE, x, y,
                             $urandom, $urandom, $urandom);
            end
            else if (cur_w == 0 || cur_h == 0)
                push_cmd(OP_READ, $urandom_range(0, 511), $urandom_range(0, 511), 0, 0, 0);
            else if (sel < 55)
                push_write(x, y);
            else
                push_cmd(OP_READ, x, y, $urandom, $urandom, $urandom);
        end
    endfunction

    function automatic logic [11:0] rand_edge(input int span);
        if ($urandom_range(0, 5) == 0)
            return 12'($urandom);
        return 12'($urandom_range(0, span + 16) - 8);
    endfunction

    initial
    begin
        int k;
        int w, h;
        logic [11:0] sz;
        rst_n       = 1'b0;
        hold_go     = 1'b0;
        error_count = 0;
        cur_w       = 0;
        cur_h       = 0;
        cmd.valid = 1'b0; cmd.operation = OP_WRITE; cmd.x_pos = '0; cmd.y_pos = '0;
        cmd.red_in = '0; cmd.green_in = '0; cmd.blue_in = '0;
        rsp.ready = 1'b0;
        cfg.valid = 1'b0; cfg.index = REG_IMAGE_WIDTH; cfg.data = '0;
        foreach (frame_model[i]) frame_model[i] = '0;
        foreach (cfg_shadow[i]) cfg_shadow[i] = '0;
        cfg_shadow[REG_IMAGE_WIDTH]  = 12'd512;
        cfg_shadow[REG_IMAGE_HEIGHT] = 12'd512;
        cfg_shadow[REG_RECT_RIGHT]   = 12'd512;
        cfg_shadow[REG_RECT_BOTTOM]  = 12'd512;
        cfg_shadow[REG_BLOCK_SIZE]   = 12'd8;
        cur_w = FRAME_W;
        cur_h = FRAME_H;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: corners at default size, then small images
        push_cmd(OP_WRITE, 511, 511, 8'hFF, 8'hFF, 8'hFF);
        push_cmd(OP_WRITE, 0, 0, 8'h00, 8'h00, 8'h00);
        push_cmd(OP_READ, 511, 511, 0, 0, 0);
        push_cmd(OP_READ, 0, 0, 0, 0, 0);
        push_cmd(OP_NONE, 5, 5, 8'hAA, 8'h55, 8'hFF);

        apply_cfg(12'd16, 12'd12, 12'd0, 12'd0, 12'd16, 12'd12, 12'd4, 12'd0);
        push_cmd(OP_WRITE, 15, 11, 8'hFF, 8'h00, 8'hFF);
        push_cmd(OP_WRITE, 16, 3, 8'hFF, 8'hFF, 8'hFF);
        push_cmd(OP_READ, 16, 3, 0, 0, 0);
        push_cmd(OP_READ, 3, 12, 0, 0, 0);
        push_cmd(OP_RUN, 0, 0, 0, 0, 0);
        push_cmd(OP_READ, 15, 11, 0, 0, 0);
        push_cmd(OP_READ, 0, 0, 0, 0, 0);

        // clipped rectangle with partial leading blocks, brightening
        apply_cfg(12'd13, 12'd9, -12'sd5, -12'sd3, 12'd11, 12'd20, 12'd3, 12'd100);
        push_cmd(OP_RUN, 0, 0, 0, 0, 0);
        push_cmd(OP_READ, 0, 0, 0, 0, 0);
        push_cmd(OP_READ, 10, 8, 0, 0, 0);
        // full darkening, then full brightening with saturation
        apply_cfg(12'd20, 12'd20, 12'd3, 12'd2, 12'd17, 12'd15, 12'd5, 12'h300);
        push_cmd(OP_RUN, 0, 0, 0, 0, 0);
        push_cmd(OP_READ, 3, 2, 0, 0, 0);
        apply_cfg(12'd20, 12'd20, 12'd0, 12'd0, 12'd20, 12'd20, 12'd2, 12'd256);
        push_cmd(OP_RUN, 0, 0, 0, 0, 0);
        push_cmd(OP_READ, 19, 19, 0, 0, 0);
        // small blocks leave the frame alone
        apply_cfg(12'd20, 12'd20, 12'd0, 12'd0, 12'd20, 12'd20, 12'd1, 12'd0);
        push_cmd(OP_RUN, 0, 0, 0, 0, 0);
        apply_cfg(12'd20, 12'd20, 12'd0, 12'd0, 12'd20, 12'd20, 12'd0, 12'd0);
        push_cmd(OP_RUN, 0, 0, 0, 0, 0);
        push_cmd(OP_READ, 7, 7, 0, 0, 0);
        // rectangles off the image or empty after clipping
        apply_cfg(12'd20, 12'd20, -12'sd9, 12'd0, -12'sd1, 12'd20, 12'd4, 12'd0);
        push_cmd(OP_RUN, 0, 0, 0, 0, 0);
        apply_cfg(12'd20, 12'd20, 12'd20, 12'd0, 12'h7FF, 12'd20, 12'd4, 12'd0);
        push_cmd(OP_RUN, 0, 0, 0, 0, 0);
        apply_cfg(12'd20, 12'd20, 12'd5, 12'd0, 12'd5, 12'd20, 12'd4, 12'd0);
        push_cmd(OP_RUN, 0, 0, 0, 0, 0);
        push_cmd(OP_READ, 5, 5, 0, 0, 0);
        // widest and tallest images, oversize registers, extreme rectangle
        apply_cfg(12'd512, 12'd1, 12'h800, 12'h800, 12'h7FF, 12'h7FF, 12'd512, 12'h1FF);
        push_cmd(OP_RUN, 0, 0, 0, 0, 0);
        push_cmd(OP_READ, 511, 0, 0, 0, 0);
        push_cmd(OP_READ, 0, 1, 0, 0, 0);
        apply_cfg(12'd1, 12'hFFF, 12'h800, 12'h800, 12'h7FF, 12'h7FF, 12'd200, 12'h200);
        push_cmd(OP_RUN, 0, 0, 0, 0, 0);
        push_cmd(OP_READ, 0, 511, 0, 0, 0);
        // empty image
        apply_cfg(12'd0, 12'd0, 12'd0, 12'd0, 12'd20, 12'd20, 12'd4, 12'd0);
        push_cmd(OP_WRITE, 0, 0, 8'h12, 8'h34, 8'h56);
        push_cmd(OP_READ, 0, 0, 0, 0, 0);
        push_cmd(OP_RUN, 0, 0, 0, 0, 0);

        // random phases
        for (k = 0; k < 9; k++)
        begin
            w  = $urandom_range(1, 24);
            h  = $urandom_range(1, 24);
            case ($urandom_range(0, 7))
                0:       sz = 12'($urandom_range(0, 1));
                1:       sz = 12'($urandom_range(9, 30));
                2:       sz = 12'($urandom);
                default: sz = 12'($urandom_range(2, 7));
            endcase
            sz[11:10] = 2'($urandom);
            apply_cfg({2'($urandom), 10'(w)}, {2'($urandom), 10'(h)},
                      rand_edge(w), rand_edge(h), rand_edge(w), rand_edge(h),
                      sz, 12'($urandom));
            if (k == 0)
            begin
                for (int n = 0; n < 40; n++)
                    push_cmd(OP_READ, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                             0, 0, 0);
                hold_go = 1'b1;
            end
            random_items(65);
        end
        drain();
        repeat (50) @(posedge clk);
        $display("Run covered %0d pixel writes, %0d pixel reads and %0d mosaic runs",
                 pixels_written, reads_checked, runs_checked);
        $display("across directed clipping, brightness and block-size corners.");
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
